/* hdl/assert_macros.svh */
// assertion helpers for the projection checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on the same edge, off while reset is high
`define ASSERT_IMPL(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");

// implication checked on the next edge, off while reset is high
`define ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");

// implication that also holds through reset
`define ASSERT_RAW(lbl, clk, a, c) \
   lbl: assert property (@(posedge clk) (a) |=> (c)) \
      else $error("assertion failed");

`endif

/* hdl/wpp_pkg.sv */
`timescale 1ns / 1ps
package wpp_pkg;
   // fixed widths
   localparam int COORD_W = 32;
   localparam int PROD_W  = 64;
   localparam int CLIP_W  = 50;
   localparam int WPOS_W  = 48;
   localparam int SIZE_W  = 14;
   localparam int QB      = 31;
   localparam int NP_W    = 78;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 64;
   // total register stages from accept to result
   localparam int LAT = 37;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_X_XY = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_ZT = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_XY = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_ZT = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_W_XY = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_W_ZT = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 4'd7;

   // reset values
   localparam logic [CSR_DAT_W-1:0] RST_X_XY = 64'h0000_0000_0001_0000;
   localparam logic [CSR_DAT_W-1:0] RST_Y_XY = 64'h0001_0000_0000_0000;
   localparam logic [CSR_DAT_W-1:0] RST_W_ZT = 64'h0001_0000_0000_0000;
   localparam logic [SIZE_W-1:0] RST_WIDTH  = 14'd1920;
   localparam logic [SIZE_W-1:0] RST_HEIGHT = 14'd1080;

   // 0.1 in q16.16
   localparam logic signed [CLIP_W-1:0] W_MIN = 50'sd6554;
   localparam logic signed [COORD_W-1:0] SAT_MAX = 32'sh7fff_ffff;
   localparam logic signed [COORD_W-1:0] SAT_MIN = 32'sh8000_0000;
endpackage

/* hdl/wpp_dot.sv */
`timescale 1ns / 1ps
module wpp_dot (
   input  logic clock,
   input  logic adv,
   input  logic signed [wpp_pkg::COORD_W-1:0] x,
   input  logic signed [wpp_pkg::COORD_W-1:0] y,
   input  logic signed [wpp_pkg::COORD_W-1:0] z,
   input  logic [wpp_pkg::CSR_DAT_W-1:0] row_xy,
   input  logic [wpp_pkg::CSR_DAT_W-1:0] row_zt,
   output logic signed [wpp_pkg::CLIP_W-1:0] dot
);
   import wpp_pkg::*;

   logic signed [PROD_W-1:0] p0_ff, p1_ff, p2_ff;
   logic signed [COORD_W-1:0] t_ff;
   logic signed [PROD_W+1:0] sum;
   logic signed [PROD_W+1:0] dot_full;
   logic signed [CLIP_W-1:0] dot_ff, dot_in;

   // stage one: exact products
   always_ff @(posedge clock) begin
      if (adv) begin
         p0_ff <= $signed(row_xy[31:0]) * x;
         p1_ff <= $signed(row_xy[63:32]) * y;
         p2_ff <= $signed(row_zt[31:0]) * z;
         t_ff  <= $signed(row_zt[63:32]);
      end
   end

   // stage two: floor of the sum to q16.16, then translation
   always_comb begin
      sum = {{2{p0_ff[PROD_W-1]}}, p0_ff} + {{2{p1_ff[PROD_W-1]}}, p1_ff}
          + {{2{p2_ff[PROD_W-1]}}, p2_ff};
      dot_full = (sum >>> 16) + {{(PROD_W+2-COORD_W){t_ff[COORD_W-1]}}, t_ff};
      dot_in = dot_full[CLIP_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dot_ff <= dot_in;
      end
   end

   assign dot = dot_ff;
endmodule

/* hdl/wpp_div.sv */
`timescale 1ns / 1ps
module wpp_div (
   input  logic clock,
   input  logic adv,
   input  logic [wpp_pkg::NP_W-1:0] num_in,
   input  logic neg_in,
   input  logic [wpp_pkg::WPOS_W-1:0] den_in,
   output logic [wpp_pkg::QB-1:0] q_out,
   output logic ovf_out,
   output logic neg_out
);
   import wpp_pkg::*;

   logic [WPOS_W-1:0] rem_ff [0:QB];
   logic [WPOS_W-1:0] rem_in [0:QB];
   logic [WPOS_W-1:0] den_ff [0:QB];
   logic [QB-1:0] lo_ff [0:QB];
   logic [QB-1:0] q_ff [0:QB];
   logic [QB-1:0] q_in [0:QB];
   logic ovf_ff [0:QB];
   logic neg_ff [0:QB];
   logic [WPOS_W-1:0] head;
   logic [WPOS_W:0] trial [1:QB];

   // entry stage: quotient overflow check and first partial remainder,
   // then one restoring step per stage
   always_comb begin
      head = {1'b0, num_in[NP_W-1:QB]};
      rem_in[0] = head;
      q_in[0] = '0;
      for (int j = 1; j <= QB; j++) begin
         trial[j] = {rem_ff[j-1], lo_ff[j-1][QB-j]};
         if (trial[j] >= {1'b0, den_ff[j-1]}) begin
            rem_in[j] = WPOS_W'(trial[j] - {1'b0, den_ff[j-1]});
            q_in[j] = {q_ff[j-1][QB-2:0], 1'b1};
         end else begin
            rem_in[j] = trial[j][WPOS_W-1:0];
            q_in[j] = {q_ff[j-1][QB-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= rem_in[0];
         q_ff[0]   <= q_in[0];
         den_ff[0] <= den_in;
         lo_ff[0]  <= num_in[QB-1:0];
         ovf_ff[0] <= head >= den_in;
         neg_ff[0] <= neg_in;
         for (int j = 1; j <= QB; j++) begin
            rem_ff[j] <= rem_in[j];
            q_ff[j]   <= q_in[j];
            den_ff[j] <= den_ff[j-1];
            lo_ff[j]  <= lo_ff[j-1];
            ovf_ff[j] <= ovf_ff[j-1];
            neg_ff[j] <= neg_ff[j-1];
         end
      end
   end

   assign q_out = q_ff[QB];
   assign ovf_out = ovf_ff[QB];
   assign neg_out = neg_ff[QB];
endmodule

/* hdl/world_to_screen_projection.sv */
`timescale 1ns / 1ps
// world point to screen pixel projection
// req channel: one world point (x, y, z, signed q16.16) per item, valid/ready.
// rsp channel: on_screen flag and pixel x/y (signed q16.16, saturated),
// one item out for every item in, in order.
// csr port: write enable, index and 64-bit data; the user must write the six
// matrix rows and the two screen sizes only while no item is in flight; the
// block itself does not enforce this. throughput one item per cycle while the
// output is not stalled. an item passes a product stage, a sum stage, a
// numerator stage, a size multiply stage, the divider entry stage, the 31-stage
// restoring divider, one quotient bit a stage, and the output register.
// when rsp_ready is low with a result waiting, the whole pipeline holds and
// req_ready drops; empty stages are not squeezed out.
// reset clears all valid bits and loads the default matrix and 1920x1080.
module world_to_screen_projection (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [31:0] req_world_x,
   input  logic signed [31:0] req_world_y,
   input  logic signed [31:0] req_world_z,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_on_screen,
   output logic signed [31:0] rsp_screen_x,
   output logic signed [31:0] rsp_screen_y,
   input  logic csr_we,
   input  logic [wpp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [wpp_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import wpp_pkg::*;

   logic [CSR_DAT_W-1:0] x_xy_ff, x_zt_ff, y_xy_ff, y_zt_ff, w_xy_ff, w_zt_ff;
   logic [SIZE_W-1:0] width_ff, height_ff;
   logic adv;
   logic v_ff [0:LAT-1];
   logic signed [CLIP_W-1:0] w2, cx2, cy2;
   logic on3_ff, on4_ff;
   logic on_pipe_ff [0:QB];
   logic signed [CLIP_W-1:0] numx3_ff, numy3_ff;
   logic [WPOS_W-1:0] w3_ff, w4_ff;
   logic signed [PROD_W-1:0] mx4_ff, my4_ff;
   logic negx, negy;
   logic [NP_W-1:0] npx, npy;
   logic [QB-1:0] qx, qy;
   logic ovfx, ovfy, nx, ny;
   logic signed [COORD_W-1:0] sx_in, sy_in, sx_ff, sy_ff;
   logic on_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_xy_ff <= RST_X_XY;
         x_zt_ff <= '0;
         y_xy_ff <= RST_Y_XY;
         y_zt_ff <= '0;
         w_xy_ff <= '0;
         w_zt_ff <= RST_W_ZT;
         width_ff <= RST_WIDTH;
         height_ff <= RST_HEIGHT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_X_XY: x_xy_ff <= csr_wdata;
            CSR_X_ZT: x_zt_ff <= csr_wdata;
            CSR_Y_XY: y_xy_ff <= csr_wdata;
            CSR_Y_ZT: y_zt_ff <= csr_wdata;
            CSR_W_XY: w_xy_ff <= csr_wdata;
            CSR_W_ZT: w_zt_ff <= csr_wdata;
            CSR_WIDTH: width_ff <= csr_wdata[SIZE_W-1:0];
            CSR_HEIGHT: height_ff <= csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline advance and valid chain
   assign adv = !v_ff[LAT-1] || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) v_ff[k] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= req_valid;
         for (int k = 1; k < LAT; k++) v_ff[k] <= v_ff[k-1];
      end
   end

   // clip x, clip y and w
   wpp_dot u_dot_w (.clock(clock), .adv(adv), .x(req_world_x), .y(req_world_y),
      .z(req_world_z), .row_xy(w_xy_ff), .row_zt(w_zt_ff), .dot(w2));
   wpp_dot u_dot_x (.clock(clock), .adv(adv), .x(req_world_x), .y(req_world_y),
      .z(req_world_z), .row_xy(x_xy_ff), .row_zt(x_zt_ff), .dot(cx2));
   wpp_dot u_dot_y (.clock(clock), .adv(adv), .x(req_world_x), .y(req_world_y),
      .z(req_world_z), .row_xy(y_xy_ff), .row_zt(y_zt_ff), .dot(cy2));

   // threshold and numerators, then scale by screen size
   always_ff @(posedge clock) begin
      if (adv) begin
         on3_ff <= w2 >= W_MIN;
         numx3_ff <= w2 + cx2;
         numy3_ff <= w2 - cy2;
         w3_ff <= w2[WPOS_W-1:0];
         on4_ff <= on3_ff;
         mx4_ff <= $signed({{(PROD_W-CLIP_W){numx3_ff[CLIP_W-1]}}, numx3_ff})
                 * $signed({{(PROD_W-SIZE_W){1'b0}}, width_ff});
         my4_ff <= $signed({{(PROD_W-CLIP_W){numy3_ff[CLIP_W-1]}}, numy3_ff})
                 * $signed({{(PROD_W-SIZE_W){1'b0}}, height_ff});
         w4_ff <= w3_ff;
      end
   end

   // fold sign so the divider sees a nonnegative dividend (times 2^15)
   always_comb begin
      negx = mx4_ff[PROD_W-1];
      negy = my4_ff[PROD_W-1];
      npx = {(negx ? ~mx4_ff[PROD_W-2:0] : mx4_ff[PROD_W-2:0]), {15{negx}}};
      npy = {(negy ? ~my4_ff[PROD_W-2:0] : my4_ff[PROD_W-2:0]), {15{negy}}};
   end

   wpp_div u_div_x (.clock(clock), .adv(adv), .num_in(npx), .neg_in(negx),
      .den_in(w4_ff), .q_out(qx), .ovf_out(ovfx), .neg_out(nx));
   wpp_div u_div_y (.clock(clock), .adv(adv), .num_in(npy), .neg_in(negy),
      .den_in(w4_ff), .q_out(qy), .ovf_out(ovfy), .neg_out(ny));

   // on-screen flag alongside the divider
   always_ff @(posedge clock) begin
      if (adv) begin
         on_pipe_ff[0] <= on4_ff;
         for (int k = 1; k <= QB; k++) on_pipe_ff[k] <= on_pipe_ff[k-1];
      end
   end

   // unfold sign, saturate, zero when off screen
   always_comb begin
      if (!on_pipe_ff[QB]) sx_in = '0;
      else if (ovfx) sx_in = nx ? SAT_MIN : SAT_MAX;
      else sx_in = nx ? ~$signed({1'b0, qx}) : $signed({1'b0, qx});
      if (!on_pipe_ff[QB]) sy_in = '0;
      else if (ovfy) sy_in = ny ? SAT_MIN : SAT_MAX;
      else sy_in = ny ? ~$signed({1'b0, qy}) : $signed({1'b0, qy});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         on_ff <= on_pipe_ff[QB];
      end
   end

   assign rsp_valid = v_ff[LAT-1];
   assign rsp_on_screen = on_ff;
   assign rsp_screen_x = sx_ff;
   assign rsp_screen_y = sy_ff;
endmodule

/* hdl/wpp_check.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wpp_check (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic signed [31:0] req_world_x,
   input logic signed [31:0] req_world_y,
   input logic signed [31:0] req_world_z,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_on_screen,
   input logic signed [31:0] rsp_screen_x,
   input logic signed [31:0] rsp_screen_y,
   input logic csr_we,
   input logic [3:0] csr_index,
   input logic [63:0] csr_wdata
);
   // a waiting result stays offered
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // a stalled output blocks intake
   `ASSERT_IMPL(a_stall_blocks, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   // off-screen items carry zero coordinates
   `ASSERT_IMPL(a_off_zero, clock, reset, rsp_valid && !rsp_on_screen,
      rsp_screen_x == 32'sd0 && rsp_screen_y == 32'sd0)
   // nothing comes out right after reset
   `ASSERT_RAW(a_reset_empty, clock, reset, !rsp_valid)
endmodule

bind world_to_screen_projection wpp_check u_wpp_check (.*);
